### design/ltc_pkg.sv
package ltc_pkg;

  // default depth of the queue between front and back
  localparam int LtcQueueDepth = 4;

  // ascii codes that steer the mapping
  localparam logic [7:0] ChLowY   = 8'h79;
  localparam logic [7:0] ChLowH   = 8'h68;
  localparam logic [7:0] ChUpY    = 8'h59;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] CaseStep = 8'h20;

  // code points used by the case change
  localparam logic [10:0] CpLowFirst = 11'h430;
  localparam logic [10:0] CpLowLast  = 11'h44F;
  localparam logic [10:0] CpLowYo    = 11'h451;
  localparam logic [10:0] CpUpYo     = 11'h401;
  localparam logic [10:0] CpCaseStep = 11'h020;

  // one accepted byte as it waits for the back part
  typedef struct packed {
    logic       held_ok;   // a byte was waiting for this one
    logic [7:0] prior;     // byte before the waiting byte
    logic [7:0] held;      // the waiting byte
    logic [7:0] cur;       // the byte just taken
    logic       last;      // cur closes the string
  } entry_t;

  function automatic logic [7:0] ascii_lower(logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= ChUpA && b <= ChUpZ) r = b + CaseStep;
    return r;
  endfunction

  // lower-case letter for cur between prev and nxt, zero for nothing
  function automatic logic [10:0] lower_letter(logic [7:0] prev, logic [7:0] cur,
                                               logic [7:0] nxt);
    logic [7:0]  c;
    logic        py;
    logic        nh;
    logic [10:0] cp;
    c  = ascii_lower(cur);
    py = (ascii_lower(prev) == ChLowY);
    nh = (ascii_lower(nxt) == ChLowH);
    case (c)
      8'h61:   cp = py ? 11'h44F : 11'h430;  // a
      8'h62:   cp = 11'h431;                 // b
      8'h76:   cp = 11'h432;                 // v
      8'h67:   cp = 11'h433;                 // g
      8'h64:   cp = 11'h434;                 // d
      8'h65:   cp = py ? 11'h44D : 11'h435;  // e
      8'h6F:   cp = py ? 11'h451 : 11'h43E;  // o
      8'h7A:   cp = nh ? 11'h436 : 11'h437;  // z
      8'h69:   cp = py ? 11'h44B : 11'h438;  // i
      8'h6A:   cp = 11'h439;                 // j
      8'h6B:   cp = nh ? 11'h445 : 11'h43A;  // k
      8'h6C:   cp = 11'h43B;                 // l
      8'h6D:   cp = 11'h43C;                 // m
      8'h6E:   cp = 11'h43D;                 // n
      8'h70:   cp = 11'h43F;                 // p
      8'h72:   cp = 11'h440;                 // r
      8'h73:   cp = nh ? 11'h448 : 11'h441;  // s
      8'h74:   cp = 11'h442;                 // t
      8'h75:   cp = py ? 11'h44E : 11'h443;  // u
      8'h77:   cp = 11'h449;                 // w
      8'h66:   cp = 11'h444;                 // f
      8'h63:   cp = nh ? 11'h447 : 11'h446;  // c
      8'h22:   cp = 11'h44A;                 // double quote
      8'h27:   cp = 11'h44C;                 // apostrophe
      8'h78:   cp = 11'h445;                 // x
      8'h79:   cp = '0;                      // y
      8'h68:   cp = '0;                      // h
      default: cp = {3'b000, c};
    endcase
    if (cur[7]) cp = '0;
    return cp;
  endfunction

  function automatic logic [10:0] make_upper(logic [10:0] cp);
    logic [10:0] r;
    r = cp;
    if (cp >= CpLowFirst && cp <= CpLowLast) r = cp - CpCaseStep;
    else if (cp == CpLowYo) r = CpUpYo;
    return r;
  endfunction

  function automatic logic [10:0] translate(logic [7:0] prev, logic [7:0] cur,
                                            logic [7:0] nxt);
    logic [10:0] cp;
    cp = lower_letter(prev, cur, nxt);
    if ((cur >= ChUpA && cur <= ChUpZ) || prev == ChUpY) cp = make_upper(cp);
    return cp;
  endfunction

endpackage

### design/ltc_if.sv
// byte stream channel
interface ltc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// code point channel
interface ltc_cp_if;
  logic        valid;
  logic        ready;
  logic [10:0] code_point;
  logic        has_char;
  logic        string_done;

  modport source (output valid, output code_point, output has_char,
                  output string_done, input ready);
  modport sink   (input valid, input code_point, input has_char,
                  input string_done, output ready);
endinterface

### design/ltc_front.sv
module ltc_front (
  input  logic              clk,
  input  logic              rst,
  ltc_byte_if.sink          bytes,
  output ltc_pkg::entry_t   push_entry,
  output logic              push_valid,
  input  logic              push_ready
);
  import ltc_pkg::*;

  logic [7:0] held_byte;
  logic [7:0] before_held_byte;
  logic       held_valid;
  logic       accept;

  // a beat is taken whenever the queue has room
  assign bytes.ready = push_ready;
  assign accept      = bytes.valid && push_ready;
  assign push_valid  = bytes.valid;

  // classify the beat against the waiting byte
  always_comb begin
    push_entry.held_ok = held_valid;
    push_entry.prior   = before_held_byte;
    push_entry.held    = held_byte;
    push_entry.cur     = bytes.in_byte;
    push_entry.last    = bytes.end_of_string;
  end

  // lookahead window
  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte        <= '0;
      before_held_byte <= '0;
      held_valid       <= 1'b0;
    end else if (accept) begin
      if (bytes.end_of_string) begin
        held_byte        <= '0;
        before_held_byte <= '0;
        held_valid       <= 1'b0;
      end else begin
        before_held_byte <= held_valid ? held_byte : 8'h00;
        held_byte        <= bytes.in_byte;
        held_valid       <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  // a closing byte leaves nothing waiting
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && bytes.end_of_string |=> !held_valid)
    else $error("window not cleared after end of string");
`endif

endmodule

### design/ltc_queue.sv
module ltc_queue #(
  parameter int DEPTH = ltc_pkg::LtcQueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  ltc_pkg::entry_t push_entry,
  input  logic            push_valid,
  output logic            push_ready,
  output ltc_pkg::entry_t head,
  output logic            head_valid,
  input  logic            pop
);
  import ltc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            do_pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

`ifndef SYNTH
  // fill level tracks the pointers
  a_count_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CntW'(DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue fill level out of step with pointers");
`endif

endmodule

### design/ltc_back.sv
module ltc_back (
  input  logic            clk,
  input  logic            rst,
  input  ltc_pkg::entry_t head,
  input  logic            head_valid,
  output logic            pop,
  ltc_cp_if.source        chars
);
  import ltc_pkg::*;

  logic        phase;       // first result given, closing result pending
  logic        phase_next;
  logic [10:0] cp_first;
  logic [10:0] cp_close;
  logic        first_ok;
  logic        load_ok;
  logic        emit;
  logic [10:0] res_cp;
  logic        res_has;
  logic        res_done;

  // both translations of the head entry
  assign cp_first = translate(head.prior, head.held, head.cur);
  assign cp_close = translate(head.held_ok ? head.held : 8'h00, head.cur, 8'h00);
  assign first_ok = head.held_ok && (cp_first != '0);
  assign load_ok  = !chars.valid || chars.ready;

  // pick the next result and decide when the entry is done
  always_comb begin
    emit       = 1'b0;
    pop        = 1'b0;
    phase_next = phase;
    res_cp     = cp_close;
    res_has    = (cp_close != '0);
    res_done   = 1'b1;
    if (head_valid) begin
      if (phase) begin
        if (load_ok) begin
          emit       = 1'b1;
          pop        = 1'b1;
          phase_next = 1'b0;
        end
      end else if (first_ok) begin
        res_cp   = cp_first;
        res_has  = 1'b1;
        res_done = 1'b0;
        if (load_ok) begin
          emit = 1'b1;
          if (head.last) phase_next = 1'b1;
          else pop = 1'b1;
        end
      end else if (head.last) begin
        if (load_ok) begin
          emit = 1'b1;
          pop  = 1'b1;
        end
      end else begin
        pop = 1'b1;
      end
    end
  end

  // output register and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= 1'b0;
      chars.valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (emit) chars.valid <= 1'b1;
      else if (chars.ready) chars.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      chars.code_point  <= res_cp;
      chars.has_char    <= res_has;
      chars.string_done <= res_done;
    end
  end

`ifndef SYNTH
  // a pending closing result belongs to a closing entry at the head
  a_phase_head: assert property (@(posedge clk) disable iff (rst)
    phase |-> (head_valid && head.last))
    else $error("closing result pending without a closing entry");

  // an empty marker only closes a string
  a_empty_done: assert property (@(posedge clk) disable iff (rst)
    chars.valid && !chars.has_char |-> chars.string_done && chars.code_point == '0)
    else $error("empty result that does not close a string");

  // a real character never carries code point zero
  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    chars.valid && chars.has_char |-> chars.code_point != '0)
    else $error("character result with zero code point");
`endif

endmodule

### design/latin_to_cyrillic_transliterator_top.sv
// channel  role    beat payload
// bytes    sink    in_byte[7:0], end_of_string
// chars    source  code_point[10:0], has_char, string_done
//
// One byte is taken per cycle while the front queue has room.
// A result leaves the output register after its entry has passed through the queue;
// a closing byte that yields two results stays at the head of the queue for both.
// Each non-closing byte waits for the next one, so its result follows that byte.
// Reset is synchronous and clears the window, the queue and the output valid.
// The queue lets the input side keep going while the output side stalls.
module latin_to_cyrillic_transliterator_top #(
  parameter int QUEUE_DEPTH = ltc_pkg::LtcQueueDepth
) (
  input  logic     clk,
  input  logic     rst,
  ltc_byte_if.sink bytes,
  ltc_cp_if.source chars
);
  import ltc_pkg::*;

  entry_t push_entry;
  logic   push_valid;
  logic   push_ready;
  entry_t head;
  logic   head_valid;
  logic   pop;

  ltc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  ltc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  ltc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .chars      (chars)
  );

endmodule
